### hw/rtl/pif_pkg.sv
package pif_pkg;

  localparam int DEF_VARIABLES = 4;
  localparam int MAX_RESULTS   = 32;

  localparam int KIND_W  = 2;
  localparam int POINT_W = 4;
  localparam int LC_W    = 3;
  localparam int COST_W  = 3;
  localparam int TOTAL_W = 8;
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [LC_W-1:0] LC_RESET = 3'd4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ON     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DC     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_on;
    logic load_dc;
    logic scan_init;
    logic pass1;
    logic pass2;
    logic flush;
  } pif_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dc_last;
    logic k_last;
  } pif_stat_t;

endpackage

### hw/rtl/prime_implicant_finder.sv
// Prime implicant finder for a Boolean function of up to VARIABLES inputs.
// A load item (kind 0 for a minterm, kind 1 for a don't-care point) leaves
// busy low, so the next item can follow at once. A finish item (kind 2)
// raises busy; the controller then makes two sweeps over every (care, dash)
// pair of the variables in use, one pair per cycle: the first sweep tests
// each cube against the loaded points and writes its implicant and prime
// flags into the cube flag memory, the second reads that memory once per
// pair for each dash count and picks out, in order of dash count, dash mask
// and care bits, the primes that cover a minterm. Results appear on the out_
// ports at most one per cycle, each for exactly one cycle and marked by
// out_valid; the receiver cannot stall them, so it must take every strobe as
// it comes. At most 32 results leave per finish; the final one carries
// out_last, and a function with no minterm gives a single result with
// out_term_valid low. Both point sets are cleared when the finish ends. The
// literal_count register is written through the cfg_ port, which is ready
// while busy is low; a value of 0 acts as 1 and values above VARIABLES act
// as VARIABLES.
module prime_implicant_finder import pif_pkg::*; #(
  parameter int VARIABLES = DEF_VARIABLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [POINT_W-1:0] in_point,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LC_W-1:0]    cfg_data,
  output logic               out_valid,
  output logic               out_term_valid,
  output logic [3:0]         out_care_bits,
  output logic [3:0]         out_dash_mask,
  output logic [COST_W-1:0]  out_lit_cost,
  output logic [TOTAL_W-1:0] out_run_cost,
  output logic               out_last
);

  pif_cmd_t  cmd;
  pif_stat_t stat;

  // The register is only written between items.
  assign cfg_ready = !busy;

  pif_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pif_datapath #(
    .VARIABLES (VARIABLES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .point          (in_point),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_term_valid (out_term_valid),
    .out_care_bits  (out_care_bits),
    .out_dash_mask  (out_dash_mask),
    .out_lit_cost   (out_lit_cost),
    .out_run_cost   (out_run_cost),
    .out_last       (out_last)
  );

endmodule

### hw/rtl/pif_ctrl.sv
module pif_ctrl import pif_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] kind,
  input  pif_stat_t         stat,
  output pif_cmd_t          cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_PASS2,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (kind)
            KIND_ON:     cmd.load_on = 1'b1;
            KIND_DC:     cmd.load_dc = 1'b1;
            KIND_FINISH: begin
              cmd.scan_init = 1'b1;
              state_nxt     = ST_PASS1;
            end
            default: ;
          endcase
        end
      end
      ST_PASS1: begin
        cmd.pass1 = 1'b1;
        if (stat.dc_last) state_nxt = ST_PASS2;
      end
      ST_PASS2: begin
        cmd.pass2 = 1'b1;
        if (stat.dc_last && stat.k_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FLUSH;
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

### hw/rtl/pif_datapath.sv
module pif_datapath import pif_pkg::*; #(
  parameter int VARIABLES = DEF_VARIABLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pif_cmd_t           cmd,
  output pif_stat_t          stat,
  input  logic [POINT_W-1:0] point,
  input  logic               cfg_we,
  input  logic [LC_W-1:0]    cfg_data,
  output logic               out_valid,
  output logic               out_term_valid,
  output logic [3:0]         out_care_bits,
  output logic [3:0]         out_dash_mask,
  output logic [COST_W-1:0]  out_lit_cost,
  output logic [TOTAL_W-1:0] out_run_cost,
  output logic               out_last
);

  localparam int V     = VARIABLES;
  localparam int PTS   = 1 << V;
  localparam int CUBES = 3 ** V;
  localparam int IDX_W = $clog2(CUBES);
  localparam int N_W   = $clog2(V + 1);

  // True when every point of the cube lies in the allowed set.
  function automatic logic cube_in(input logic [V-1:0] c, input logic [V-1:0] d,
                                   input logic [PTS-1:0] allow);
    logic ok;
    ok = 1'b1;
    for (int p = 0; p < PTS; p++) begin
      if (((V'(p) & ~d) == c) && !allow[p]) ok = 1'b0;
    end
    return ok;
  endfunction

  // True when some point of the cube lies in the given set.
  function automatic logic cube_hits(input logic [V-1:0] c, input logic [V-1:0] d,
                                     input logic [PTS-1:0] set);
    logic hit;
    hit = 1'b0;
    for (int p = 0; p < PTS; p++) begin
      if (((V'(p) & ~d) == c) && set[p]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Base-three cube address: a dash is digit 2, a fixed bit its value.
  function automatic logic [IDX_W-1:0] cube_idx(input logic [V-1:0] c,
                                                input logic [V-1:0] d);
    logic [IDX_W-1:0] acc;
    logic [IDX_W-1:0] w;
    acc = '0;
    w   = IDX_W'(1);
    for (int i = 0; i < V; i++) begin
      if (d[i])      acc = acc + (w << 1);
      else if (c[i]) acc = acc + w;
      w = w + (w << 1);
    end
    return acc;
  endfunction

  logic [LC_W-1:0]    lc_r;
  logic [PTS-1:0]     on_r, dc_r;
  logic [V-1:0]       c_r, d_r;
  logic [N_W-1:0]     k_r;
  logic [N_W-1:0]     n_used;
  logic [V-1:0]       full;
  logic [V-1:0]       pt;
  logic [PTS-1:0]     allow;
  logic [IDX_W-1:0]   idx;
  logic               impl;
  logic [V-1:0]       nb_impl;
  logic               prime;
  logic               disjoint;
  logic               issue;

  logic [1:0]         flags_mem [CUBES];
  logic [1:0]         flag_rd_r;

  logic               rd_pend_r;
  logic [V-1:0]       c_s_r, d_s_r;
  logic [COST_W-1:0]  cost_s_r;
  logic               hit_s_r;

  logic [CNT_W-1:0]   count_r;
  logic [TOTAL_W-1:0] sum_r;
  logic [TOTAL_W:0]   sum_wide;
  logic [TOTAL_W-1:0] sum_nxt;
  logic               qual;

  logic               have_pend_r;
  logic [V-1:0]       pc_r, pd_r;
  logic [COST_W-1:0]  pcost_r;
  logic [TOTAL_W-1:0] psum_r;

  logic               out_valid_r, out_term_valid_r, out_last_r;
  logic [3:0]         out_care_r, out_dash_r;
  logic [COST_W-1:0]  out_cost_r;
  logic [TOTAL_W-1:0] out_total_r;

  always_comb begin
    if (lc_r == '0)               n_used = N_W'(1);
    else if (32'(lc_r) > V)       n_used = N_W'(V);
    else                          n_used = N_W'(lc_r);
  end

  assign full     = ~({V{1'b1}} << n_used);
  assign pt       = V'(32'(point)) & full;
  assign allow    = on_r | dc_r;
  assign idx      = cube_idx(c_r, d_r);
  assign disjoint = ((c_r & d_r) == '0);
  assign impl     = cube_in(c_r, d_r, allow);

  always_comb begin
    for (int b = 0; b < V; b++) begin
      nb_impl[b] = cube_in(c_r & ~(V'(1) << b), d_r | (V'(1) << b), allow);
    end
  end

  // Prime: no cube with one more dash among the used variables is an implicant.
  assign prime = impl && ((nb_impl & ~d_r & full) == '0);

  assign issue = cmd.pass2 && disjoint && (N_W'($countones(d_r)) == k_r);

  assign stat.dc_last = (c_r == full) && (d_r == full);
  assign stat.k_last  = (k_r == n_used);

  assign sum_wide = {1'b0, sum_r} + (TOTAL_W + 1)'(cost_s_r);
  assign sum_nxt  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
  assign qual     = rd_pend_r && (flag_rd_r == 2'b11) && hit_s_r &&
                    (count_r < CNT_W'(MAX_RESULTS));

  // Cube flag store: written during the first pass, read during the second.
  always_ff @(posedge clk) begin
    if (cmd.pass1 && disjoint) flags_mem[idx] <= {prime, impl};
    flag_rd_r <= flags_mem[idx];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r        <= LC_RESET;
      on_r        <= '0;
      dc_r        <= '0;
      c_r         <= '0;
      d_r         <= '0;
      k_r         <= '0;
      rd_pend_r   <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) lc_r <= cfg_data;
      if (cmd.load_on) on_r[pt] <= 1'b1;
      if (cmd.load_dc) dc_r[pt] <= 1'b1;

      if (cmd.scan_init) begin
        c_r         <= '0;
        d_r         <= '0;
        k_r         <= '0;
        count_r     <= '0;
        sum_r       <= '0;
        have_pend_r <= 1'b0;
      end else if (cmd.pass1 || cmd.pass2) begin
        if (c_r == full) begin
          c_r <= '0;
          if (d_r == full) begin
            d_r <= '0;
            if (cmd.pass2) k_r <= k_r + N_W'(1);
          end else begin
            d_r <= d_r + V'(1);
          end
        end else begin
          c_r <= c_r + V'(1);
        end
      end

      rd_pend_r   <= issue;
      out_valid_r <= (qual && have_pend_r) || cmd.flush;

      if (qual) begin
        count_r     <= count_r + CNT_W'(1);
        sum_r       <= sum_nxt;
        have_pend_r <= 1'b1;
      end

      if (cmd.flush) begin
        have_pend_r <= 1'b0;
        on_r        <= '0;
        dc_r        <= '0;
      end
    end
  end

  // Payload: read stage, held prime and the result register.
  always_ff @(posedge clk) begin
    c_s_r    <= c_r;
    d_s_r    <= d_r;
    cost_s_r <= COST_W'(n_used) - COST_W'(k_r);
    hit_s_r  <= cube_hits(c_r, d_r, on_r);

    if (qual) begin
      pc_r    <= c_s_r;
      pd_r    <= d_s_r;
      pcost_r <= cost_s_r;
      psum_r  <= sum_nxt;
    end

    if (qual && have_pend_r) begin
      out_term_valid_r <= 1'b1;
      out_care_r       <= 4'(pc_r);
      out_dash_r       <= 4'(pd_r);
      out_cost_r       <= pcost_r;
      out_total_r      <= psum_r;
      out_last_r       <= 1'b0;
    end else if (cmd.flush) begin
      out_last_r <= 1'b1;
      if (have_pend_r) begin
        out_term_valid_r <= 1'b1;
        out_care_r       <= 4'(pc_r);
        out_dash_r       <= 4'(pd_r);
        out_cost_r       <= pcost_r;
        out_total_r      <= psum_r;
      end else begin
        out_term_valid_r <= 1'b0;
        out_care_r       <= '0;
        out_dash_r       <= '0;
        out_cost_r       <= '0;
        out_total_r      <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_term_valid = out_term_valid_r;
  assign out_care_bits  = out_care_r;
  assign out_dash_mask  = out_dash_r;
  assign out_lit_cost   = out_cost_r;
  assign out_run_cost   = out_total_r;
  assign out_last       = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RESULTS))
    else $error("more primes accepted than results allowed");

  a_flush_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> out_valid && out_last)
    else $error("finish did not end with a last result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_term_valid |-> out_last && out_run_cost == '0 &&
                                     out_dash_mask == '0)
    else $error("empty answer malformed");

  a_cube_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_term_valid |-> (out_care_bits & out_dash_mask) == '0 &&
                                    out_run_cost >= TOTAL_W'(out_lit_cost))
    else $error("prime has care bits under a dash or a short total");

endmodule

### tb/sv/testbench.sv
module testbench;
  import pif_pkg::*;

  // The fourth kind code has no meaning for the block; items that carry it
  // must be dropped without any effect on the point sets.
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  // Quiet cycles before a literal_count write once no result is pending.
  // Load items never raise busy, so a wait of SETTLE_CYCLES is plenty.
  localparam int SETTLE_CYCLES = 4;
  // Drain time after the last expected result: a bit more than one full
  // finish sweep at four variables.
  localparam int TAIL_CYCLES   = 1600;
  // The last stretch of the item list is sent without random pauses.
  localparam int CALM_ITEMS    = 30;
  localparam int RANDOM_ITEMS  = 90;
  localparam int REPORT_LIMIT  = 10;

  // One entry of the send list: either an item for the start/busy port or a
  // write of the literal_count register.
  typedef struct packed {
    bit                 is_cfg;
    logic [KIND_W-1:0]  kind;
    logic [POINT_W-1:0] point;
    logic [LC_W-1:0]    lc;
  } work_item_t;

  // One result as it appears on the out_ ports.
  typedef struct packed {
    logic               term_valid;
    logic [3:0]         care_bits;
    logic [3:0]         dash_mask;
    logic [COST_W-1:0]  lit_cost;
    logic [TOTAL_W-1:0] run_cost;
    logic               last;
  } prime_term_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic [KIND_W-1:0]  in_kind   = '0;
  logic [POINT_W-1:0] in_point  = '0;
  logic               cfg_valid = 1'b0;
  logic [LC_W-1:0]    cfg_data  = '0;
  logic               busy;
  logic               cfg_ready;
  logic               out_valid;
  logic               out_term_valid;
  logic [3:0]         out_care_bits;
  logic [3:0]         out_dash_mask;
  logic [COST_W-1:0]  out_lit_cost;
  logic [TOTAL_W-1:0] out_run_cost;
  logic               out_last;

  prime_implicant_finder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_point       (in_point),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_term_valid (out_term_valid),
    .out_care_bits  (out_care_bits),
    .out_dash_mask  (out_dash_mask),
    .out_lit_cost   (out_lit_cost),
    .out_run_cost   (out_run_cost),
    .out_last       (out_last)
  );

  // Items still to be sent, in order, and results still to be seen.
  work_item_t  pending_items[$];
  prime_term_t expected_terms[$];

  // Shadow state of the block: the two point sets and the register.
  bit [15:0]       on_bits  = '0;
  bit [15:0]       dc_bits  = '0;
  logic [LC_W-1:0] lit_reg  = LC_RESET;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_taken  = 0;
  int unsigned finishes     = 0;
  int unsigned cfg_writes   = 0;
  int unsigned primes_seen  = 0;

  // Driver-side bookkeeping.
  int gap_left = 0;
  int settle   = 0;

  // Plan-side copy of the register, used only while the list is built so
  // that loads can be aimed at the variables in use.
  logic [LC_W-1:0] plan_lc = LC_RESET;
  int              random_items = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Number of variables in use: 0 behaves as 1, anything above the
  // variable count of the block is clamped to it.
  function automatic int vars_in_use();
    if (lit_reg == 0) return 1;
    if (lit_reg > DEF_VARIABLES) return DEF_VARIABLES;
    return int'(lit_reg);
  endfunction

  // True when every point of the cube is a minterm or a don't-care point,
  // i.e. the cube is an implicant.
  function automatic bit cube_fits(logic [3:0] care, logic [3:0] dash);
    logic [3:0] sub;
    for (int s = 0; s < 16; s++) begin
      sub = 4'(s);
      if ((sub & ~dash) == 4'd0 && !(on_bits[care | sub] || dc_bits[care | sub]))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // True when the cube contains at least one minterm.
  function automatic bit cube_hits(logic [3:0] care, logic [3:0] dash);
    logic [3:0] sub;
    for (int s = 0; s < 16; s++) begin
      sub = 4'(s);
      if ((sub & ~dash) == 4'd0 && on_bits[care | sub]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the results of a finish item. Primes are walked in the order
  // the block emits them: dash count first, then dash mask, then care bits.
  // A prime is an implicant that no implicant with one more dash contains.
  function automatic void predict_primes();
    int          n;
    int          full;
    int          sent;
    int          cost;
    int          total;
    logic [3:0]  care;
    logic [3:0]  dash;
    logic [3:0]  bitm;
    bit          is_prime;
    prime_term_t t;
    n     = vars_in_use();
    full  = (1 << n) - 1;
    sent  = 0;
    total = 0;
    for (int k = 0; k <= n; k++) begin
      for (int di = 0; di <= full; di++) begin
        dash = 4'(di);
        if ($countones(dash) != k) continue;
        for (int ci = 0; ci <= full; ci++) begin
          care = 4'(ci);
          if ((care & dash) != 4'd0) continue;
          if (!cube_fits(care, dash) || !cube_hits(care, dash)) continue;
          if (sent >= MAX_RESULTS) continue;
          is_prime = 1'b1;
          for (int b = 0; b < n; b++) begin
            bitm = 4'(1 << b);
            if ((dash & bitm) == 4'd0 && cube_fits(care & ~bitm, dash | bitm))
              is_prime = 1'b0;
          end
          if (!is_prime) continue;
          cost  = n - k;
          total = total + cost;
          if (total > 255) total = 255;
          t = prime_term_t'{1'b1, care, dash, COST_W'(cost), TOTAL_W'(total), 1'b0};
          expected_terms.push_back(t);
          sent++;
        end
      end
    end
    // A function without any covered minterm still answers with one result.
    if (sent == 0) begin
      t      = '0;
      t.last = 1'b1;
      expected_terms.push_back(t);
    end else begin
      expected_terms[expected_terms.size() - 1].last = 1'b1;
    end
  endfunction

  // Applies one accepted item to the shadow state. Points are masked to the
  // variables in use when they are loaded; a point in both sets simply ends
  // up with both bits set and counts as a minterm in the prime search.
  function automatic void predict_item(work_item_t it);
    logic [3:0] p;
    p = it.point & 4'((1 << vars_in_use()) - 1);
    case (it.kind)
      KIND_ON:     on_bits[p] = 1'b1;
      KIND_DC:     dc_bits[p] = 1'b1;
      KIND_FINISH: begin
        predict_primes();
        on_bits = '0;
        dc_bits = '0;
        finishes++;
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(string why, prime_term_t want, prime_term_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] %s: expected tv=%0d care=%b dash=%b cost=%0d total=%0d last=%0d",
               $realtime, why, want.term_valid, want.care_bits, want.dash_mask,
               want.lit_cost, want.run_cost, want.last);
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t]   got      tv=%0d care=%b dash=%b cost=%0d total=%0d last=%0d",
               $realtime, got.term_valid, got.care_bits, got.dash_mask,
               got.lit_cost, got.run_cost, got.last);
  endfunction

  // ---------------------------------------------------------------------
  // Item list
  // ---------------------------------------------------------------------

  function automatic void add_load(logic [KIND_W-1:0] kind, int point);
    pending_items.push_back(work_item_t'{1'b0, kind, POINT_W'(point), '0});
  endfunction

  function automatic void add_cfg(int value);
    pending_items.push_back(work_item_t'{1'b1, KIND_NONE, '0, LC_W'(value)});
    plan_lc = LC_W'(value);
  endfunction

  // A well-formed load sequence with random content: each point over the
  // variables in use may become a minterm or a don't-care point, each kind
  // with its own random density, sometimes with junk in the unused high
  // bits, and the sequence is closed by a finish.
  function automatic void add_function();
    int n;
    int on_pct;
    int dc_pct;
    int roll;
    int high;
    n      = (plan_lc == 0) ? 1 : (plan_lc > DEF_VARIABLES) ? DEF_VARIABLES : int'(plan_lc);
    on_pct = $urandom_range(0, 45);
    dc_pct = $urandom_range(0, 30);
    for (int p = 0; p < (1 << n); p++) begin
      roll = $urandom_range(0, 99);
      high = (n < 4 && $urandom_range(0, 3) == 0) ? ($urandom_range(0, 15) << n) : 0;
      if (roll < on_pct) begin
        add_load(KIND_ON, (p | high) & 15);
        random_items++;
      end else if (roll < on_pct + dc_pct) begin
        add_load(KIND_DC, (p | high) & 15);
        random_items++;
      end
      // Now and then a point lands in both sets.
      if (roll < on_pct && $urandom_range(0, 9) == 0) begin
        add_load(KIND_DC, p);
        random_items++;
      end
    end
    add_load(KIND_FINISH, $urandom_range(0, 15));
    random_items++;
  endfunction

  // Noise: random kinds and points, the unknown kind among them, closed by a finish.
  function automatic void add_noise();
    int count;
    logic [KIND_W-1:0] kind;
    count = $urandom_range(0, 6);
    for (int i = 0; i < count; i++) begin
      kind = KIND_W'($urandom_range(0, 3));
      if (kind == KIND_FINISH) kind = KIND_NONE;
      add_load(kind, $urandom_range(0, 15));
      if (kind != KIND_NONE) random_items++;
    end
    add_load(KIND_FINISH, $urandom_range(0, 15));
    random_items++;
  endfunction

  function automatic void build_items();
    int pick;
    // Empty function straight out of reset: one empty answer, and the reset
    // value of the register (four variables) is in force.
    add_load(KIND_FINISH, 0);
    // Corners of the point range, a don't-care point and an item of the
    // unknown kind that must leave the sets alone.
    add_load(KIND_ON, 0);
    add_load(KIND_ON, 15);
    add_load(KIND_DC, 3);
    add_load(KIND_NONE, 9);
    add_load(KIND_FINISH, 15);
    // Two variables, everything allowed: a single all-dash prime of cost 0.
    // Point 13 is wider than two bits and must fold onto point 1.
    add_cfg(2);
    add_load(KIND_ON, 0);
    add_load(KIND_DC, 13);
    add_load(KIND_DC, 2);
    add_load(KIND_ON, 3);
    add_load(KIND_FINISH, 0);
    // Four variables again; point 5 is loaded into both sets.
    add_cfg(4);
    add_load(KIND_ON, 5);
    add_load(KIND_DC, 5);
    add_load(KIND_ON, 7);
    add_load(KIND_ON, 10);
    add_load(KIND_FINISH, 0);
    // A zero register acts as one variable; 14 folds onto 0.
    add_cfg(0);
    add_load(KIND_ON, 14);
    add_load(KIND_ON, 1);
    add_load(KIND_FINISH, 0);
    // The largest register value is clamped to four variables.
    add_cfg(7);
    add_load(KIND_ON, 8);
    add_load(KIND_DC, 9);
    add_load(KIND_FINISH, 0);
    add_cfg(1);
    add_load(KIND_DC, 1);
    add_load(KIND_FINISH, 0);

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) add_cfg($urandom_range(0, 7));
      pick = $urandom_range(0, 9);
      if (pick == 0) add_noise();
      else add_function();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  // At each rising edge the driver first settles what the previous cycle
  // handed over, then decides what to present next. An item is taken when
  // start is high and busy is low; a register write when cfg_valid and
  // cfg_ready are both high. A raised start or cfg_valid stays up until it is
  // taken. Register writes wait until every expected result has come and
  // SETTLE_CYCLES quiet cycles have passed, so they only land while the block is idle.
  always @(posedge clk) begin
    bit drive_start;
    bit drive_cfg;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      drive_start = 1'b0;
      drive_cfg   = 1'b0;
      if (start && !busy) begin
        predict_item(pending_items.pop_front());
        items_taken++;
      end else if (cfg_valid && cfg_ready) begin
        lit_reg = pending_items[0].lc;
        void'(pending_items.pop_front());
        cfg_writes++;
        settle = 0;
      end else begin
        drive_start = start;
        drive_cfg   = cfg_valid;
      end

      if (!drive_start && !drive_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          if (pending_items[0].is_cfg) begin
            if (expected_terms.size() == 0) begin
              if (settle >= SETTLE_CYCLES) drive_cfg = 1'b1;
              else settle++;
            end else begin
              settle = 0;
            end
          end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
            // Sender-side pause; it can fall on any phase of the block's work.
            gap_left = $urandom_range(1, 10) - 1;
          end else begin
            drive_start = 1'b1;
          end
        end
      end

      start     <= drive_start;
      cfg_valid <= drive_cfg;
      if (drive_start) begin
        in_kind  <= pending_items[0].kind;
        in_point <= pending_items[0].point;
      end
      if (drive_cfg) cfg_data <= pending_items[0].lc;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------
  // Every strobed result is compared field by field with the oldest
  // expectation. The receiver never stalls, so each strobe is one result.
  always @(posedge clk) begin
    prime_term_t got;
    prime_term_t want;
    if (rst_n && out_valid) begin
      got = prime_term_t'{out_term_valid, out_care_bits, out_dash_mask,
                          out_lit_cost, out_run_cost, out_last};
      results_seen++;
      if (got.term_valid === 1'b1) primes_seen++;
      if (expected_terms.size() == 0) begin
        report_mismatch("result with nothing expected", '0, got);
      end else begin
        want = expected_terms.pop_front();
        if (got.term_valid !== want.term_valid || got.care_bits !== want.care_bits ||
            got.dash_mask !== want.dash_mask || got.lit_cost !== want.lit_cost ||
            got.run_cost !== want.run_cost || got.last !== want.last)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------
  initial begin
    build_items();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Wait for every item to be taken and every result to arrive, then give
    // the block time to show any stray result.
    while (pending_items.size() != 0 || expected_terms.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d finish items) and %0d literal_count writes.",
             items_taken, finishes, cfg_writes);
    $display("Compared %0d results, %0d of them prime implicants; %0d mismatches.",
             results_seen, primes_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Safety net: a hung handshake or a missing result ends the run here.
  initial begin
    #10000000;
    $display("Timed out with %0d items unsent and %0d results outstanding.",
             pending_items.size(), expected_terms.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pif_pkg.sv
hw/rtl/pif_ctrl.sv
hw/rtl/pif_datapath.sv
hw/rtl/prime_implicant_finder.sv
tb/sv/testbench.sv
